// ===== hw/rtl/afd_pkg.sv =====
`default_nettype none

package afd_pkg;

  // Field widths of the item channels.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned CODE_W   = 3;

  // Configuration port geometry: 32-bit data words, two registers at byte addresses 0 and 4.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register indexes, taken from the word address bit.
  localparam logic REG_START_DELIM   = 1'b0;
  localparam logic REG_STATUS_OFFSET = 1'b1;

  // Register reset values.
  localparam logic [BYTE_W-1:0]   START_DELIM_RST   = 8'h7E;
  localparam logic [OFFSET_W-1:0] STATUS_OFFSET_RST = 16'd14;

  // Checksum seed.
  localparam logic [BYTE_W-1:0] SUM_SEED = 8'hFF;

  // Status classes.
  localparam logic [CODE_W-1:0] STATUS_OK           = 3'd0;
  localparam logic [CODE_W-1:0] STATUS_TX_FAILURE   = 3'd4;
  localparam logic [CODE_W-1:0] STATUS_UNKNOWN      = 3'd5;

  // Frame parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CHECK  = 5'b10000
  } phase_e;

  // Maps the captured status byte to its class; unknown if not seen or out of range.
  function automatic logic [CODE_W-1:0] status_class(input logic            seen,
                                                     input logic [BYTE_W-1:0] value);
    logic [CODE_W-1:0] code;
    if (seen && (value <= BYTE_W'(STATUS_TX_FAILURE))) begin
      code = value[CODE_W-1:0];
    end else begin
      code = STATUS_UNKNOWN;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/afd_in_if.sv =====
`default_nettype none

// Received byte channel.
interface afd_in_if;
  logic                         valid;
  logic                         ready;
  logic [afd_pkg::BYTE_W-1:0]   rx_byte;
  logic                         line_error;

  modport source (output valid, output rx_byte, output line_error, input ready);
  modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/afd_out_if.sv =====
`default_nettype none

// Deframed byte channel.
interface afd_out_if;
  logic                         valid;
  logic                         ready;
  logic [afd_pkg::BYTE_W-1:0]   data_byte;
  logic [afd_pkg::OFFSET_W-1:0] byte_offset;
  logic                         last;
  logic                         checksum_ok;
  logic [afd_pkg::OFFSET_W-1:0] frame_length;
  logic [afd_pkg::CODE_W-1:0]   status_code;
  logic                         status_seen;
  logic                         error_seen;

  modport source (output valid, output data_byte, output byte_offset, output last,
                  output checksum_ok, output frame_length, output status_code,
                  output status_seen, output error_seen, input ready);
  modport sink   (input valid, input data_byte, input byte_offset, input last,
                  input checksum_ok, input frame_length, input status_code,
                  input status_seen, input error_seen, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/api_frame_deframer_core.sv =====
// A data or checksum byte reaches the result channel in the cycle after it is accepted.
// One byte per cycle while results are taken; parser and result register update in one pass.
// The result register decouples the sides: a byte is taken while the previous result is drained.
// Reset (rst_ni low, asynchronous) returns the parser to delimiter hunting, empties the result
// register and restores start_delimiter to 0x7E and status_offset to 14.
`default_nettype none

module api_frame_deframer_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [afd_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [afd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [afd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // Item channels
  afd_in_if.sink                                 rx,
  afd_out_if.source                              tx
);

  // Configuration registers.
  logic [afd_pkg::BYTE_W-1:0]   start_delim_q;
  logic [afd_pkg::OFFSET_W-1:0] status_offset_q;
  logic                         cfg_write;
  logic                         reg_idx;

  // Parser state.
  afd_pkg::phase_e              phase_q, phase_d;
  logic [afd_pkg::OFFSET_W-1:0] length_q, length_d;
  logic [afd_pkg::OFFSET_W-1:0] count_q, count_d;
  logic [afd_pkg::BYTE_W-1:0]   sum_q, sum_d;
  logic [afd_pkg::BYTE_W-1:0]   status_byte_q, status_byte_d;
  logic                         status_flag_q, status_flag_d;
  logic                         error_flag_q, error_flag_d;

  // Result register.
  logic                         out_valid_q, out_valid_d;
  logic [afd_pkg::BYTE_W-1:0]   out_data_q, out_data_d;
  logic [afd_pkg::OFFSET_W-1:0] out_offset_q, out_offset_d;
  logic                         out_last_q, out_last_d;
  logic                         out_ok_q, out_ok_d;
  logic [afd_pkg::OFFSET_W-1:0] out_length_q;
  logic [afd_pkg::CODE_W-1:0]   out_code_q, out_code_d;
  logic                         out_seen_q, out_seen_d;
  logic                         out_err_q;

  logic                         in_accept;
  logic                         emit;
  logic [afd_pkg::OFFSET_W-1:0] count_inc;
  logic [afd_pkg::OFFSET_W-1:0] length_full;

  // Configuration writes and reads.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      afd_pkg::REG_START_DELIM:   prdata = afd_pkg::APB_DATA_W'(start_delim_q);
      afd_pkg::REG_STATUS_OFFSET: prdata = afd_pkg::APB_DATA_W'(status_offset_q);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delim_q   <= afd_pkg::START_DELIM_RST;
      status_offset_q <= afd_pkg::STATUS_OFFSET_RST;
    end else if (cfg_write) begin
      if (reg_idx == afd_pkg::REG_START_DELIM) begin
        start_delim_q <= pwdata[afd_pkg::BYTE_W-1:0];
      end else begin
        status_offset_q <= pwdata[afd_pkg::OFFSET_W-1:0];
      end
    end
  end

  // A byte is taken whenever the result register is empty or being drained.
  assign rx.ready  = !out_valid_q || tx.ready;
  assign in_accept = rx.valid && rx.ready;

  assign count_inc   = count_q + afd_pkg::OFFSET_W'(1);
  assign length_full = {length_q[afd_pkg::OFFSET_W-1:afd_pkg::BYTE_W], rx.rx_byte};

  // Parser next state and result for the accepted byte.
  always_comb begin
    phase_d       = phase_q;
    length_d      = length_q;
    count_d       = count_q;
    sum_d         = sum_q;
    status_byte_d = status_byte_q;
    status_flag_d = status_flag_q;
    error_flag_d  = error_flag_q | rx.line_error;
    emit          = 1'b0;
    out_data_d    = rx.rx_byte;
    out_offset_d  = count_q;
    out_last_d    = 1'b0;
    out_ok_d      = 1'b0;
    out_code_d    = afd_pkg::STATUS_OK;
    out_seen_d    = 1'b0;
    unique case (phase_q)
      afd_pkg::PH_HUNT: begin
        error_flag_d = error_flag_q;
        if (rx.rx_byte == start_delim_q) begin
          phase_d       = afd_pkg::PH_LEN_HI;
          length_d      = '0;
          count_d       = '0;
          sum_d         = afd_pkg::SUM_SEED;
          status_byte_d = '0;
          status_flag_d = 1'b0;
          error_flag_d  = rx.line_error;
        end
      end
      afd_pkg::PH_LEN_HI: begin
        length_d = {rx.rx_byte, afd_pkg::BYTE_W'(0)};
        phase_d  = afd_pkg::PH_LEN_LO;
      end
      afd_pkg::PH_LEN_LO: begin
        length_d = length_full;
        phase_d  = (length_full == '0) ? afd_pkg::PH_CHECK : afd_pkg::PH_DATA;
      end
      afd_pkg::PH_DATA: begin
        emit  = 1'b1;
        sum_d = sum_q - rx.rx_byte;
        if (count_q == status_offset_q) begin
          status_byte_d = rx.rx_byte;
          status_flag_d = 1'b1;
        end
        count_d = count_inc;
        if (count_inc >= length_q) begin
          phase_d = afd_pkg::PH_CHECK;
        end
      end
      afd_pkg::PH_CHECK: begin
        emit         = 1'b1;
        out_offset_d = length_q;
        out_last_d   = 1'b1;
        out_ok_d     = (sum_q == rx.rx_byte);
        out_code_d   = afd_pkg::status_class(status_flag_q, status_byte_q);
        out_seen_d   = status_flag_q;
        phase_d      = afd_pkg::PH_HUNT;
      end
      default: begin
        phase_d = afd_pkg::PH_HUNT;
      end
    endcase
  end

  // Result register fills on an emitting byte and empties when taken.
  always_comb begin
    if (in_accept) begin
      out_valid_d = emit;
    end else if (tx.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= afd_pkg::PH_HUNT;
      length_q      <= '0;
      count_q       <= '0;
      sum_q         <= afd_pkg::SUM_SEED;
      status_byte_q <= '0;
      status_flag_q <= 1'b0;
      error_flag_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        phase_q       <= phase_d;
        length_q      <= length_d;
        count_q       <= count_d;
        sum_q         <= sum_d;
        status_byte_q <= status_byte_d;
        status_flag_q <= status_flag_d;
        error_flag_q  <= error_flag_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_data_q   <= out_data_d;
      out_offset_q <= out_offset_d;
      out_last_q   <= out_last_d;
      out_ok_q     <= out_ok_d;
      out_length_q <= length_q;
      out_code_q   <= out_code_d;
      out_seen_q   <= out_seen_d;
      out_err_q    <= error_flag_d;
    end
  end

  assign tx.valid        = out_valid_q;
  assign tx.data_byte    = out_data_q;
  assign tx.byte_offset  = out_offset_q;
  assign tx.last         = out_last_q;
  assign tx.checksum_ok  = out_ok_q;
  assign tx.frame_length = out_length_q;
  assign tx.status_code  = out_code_q;
  assign tx.status_seen  = out_seen_q;
  assign tx.error_seen   = out_err_q;

  // The checksum result always sits at the end of the frame data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_offset_q == out_length_q)
    else $error("checksum result offset differs from frame length");

  // A data result always lies inside the frame and carries no summary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |->
      (out_offset_q < out_length_q) && !out_ok_q && !out_seen_q &&
      (out_code_q == afd_pkg::STATUS_OK))
    else $error("data result outside frame or with summary fields set");

  // The checksum byte closes the frame and hunting resumes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (phase_q == afd_pkg::PH_CHECK) |=>
      (phase_q == afd_pkg::PH_HUNT) && out_valid_q && out_last_q)
    else $error("checksum byte did not close the frame");

endmodule

`default_nettype wire

// ===== dv/api_frame_deframer_core_test.sv =====
`timescale 1ns / 1ps

module api_frame_deframer_core_test;

  // Received byte as offered to the block.
  typedef struct packed {
    logic [afd_pkg::BYTE_W-1:0] rx_byte;
    logic                       line_error;
  } rx_item_t;

  // Deframed byte as it should leave the block.
  typedef struct packed {
    logic [afd_pkg::BYTE_W-1:0]   data_byte;
    logic [afd_pkg::OFFSET_W-1:0] byte_offset;
    logic                         last;
    logic                         checksum_ok;
    logic [afd_pkg::OFFSET_W-1:0] frame_length;
    logic [afd_pkg::CODE_W-1:0]   status_code;
    logic                         status_seen;
    logic                         error_seen;
  } deframed_t;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [afd_pkg::APB_ADDR_W-1:0] paddr;
  logic [afd_pkg::APB_DATA_W-1:0] pwdata;
  logic [afd_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  afd_in_if  rx_ch ();
  afd_out_if tx_ch ();

  api_frame_deframer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_ch),
    .tx      (tx_ch)
  );

  rx_item_t    pending_q[$];
  deframed_t   deframed_q[$];
  int unsigned queued_items;
  int unsigned fail_count;
  int unsigned stuck_cycles;
  bit          in_fire;
  bit          out_fire;

  // Sender and receiver pacing.
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned pattern_age;
  logic [15:0] stall_mask;
  logic [3:0]  pattern_idx;
  bit          no_idle;

  // Shadow of the block's registers and parser state.
  logic [afd_pkg::BYTE_W-1:0]   cfg_delim;
  logic [afd_pkg::OFFSET_W-1:0] cfg_status_off;
  afd_pkg::phase_e              pr_phase;
  logic [afd_pkg::OFFSET_W-1:0] pr_length;
  logic [afd_pkg::OFFSET_W-1:0] pr_count;
  logic [afd_pkg::BYTE_W-1:0]   pr_sum;
  logic [afd_pkg::BYTE_W-1:0]   pr_status;
  logic                         pr_status_seen;
  logic                         pr_error;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advances the shadow parser by one received byte and records any deframed byte.
  task automatic deframe_step(input logic [afd_pkg::BYTE_W-1:0] b, input logic err);
    deframed_t res;
    res = '0;
    case (pr_phase)
      afd_pkg::PH_HUNT: begin
        if (b == cfg_delim) begin
          pr_phase       = afd_pkg::PH_LEN_HI;
          pr_length      = '0;
          pr_count       = '0;
          pr_sum         = afd_pkg::SUM_SEED;
          pr_status      = '0;
          pr_status_seen = 1'b0;
          pr_error       = err;
        end
      end
      afd_pkg::PH_LEN_HI: begin
        pr_error  = pr_error | err;
        pr_length = {b, 8'h00};
        pr_phase  = afd_pkg::PH_LEN_LO;
      end
      afd_pkg::PH_LEN_LO: begin
        pr_error  = pr_error | err;
        pr_length = pr_length | afd_pkg::OFFSET_W'(b);
        pr_phase  = (pr_length == 0) ? afd_pkg::PH_CHECK : afd_pkg::PH_DATA;
      end
      afd_pkg::PH_DATA: begin
        pr_error = pr_error | err;
        pr_sum   = pr_sum - b;
        if (pr_count == cfg_status_off) begin
          pr_status      = b;
          pr_status_seen = 1'b1;
        end
        res.data_byte    = b;
        res.byte_offset  = pr_count;
        res.frame_length = pr_length;
        res.error_seen   = pr_error;
        deframed_q.push_back(res);
        pr_count = pr_count + 1'b1;
        if (pr_count >= pr_length) pr_phase = afd_pkg::PH_CHECK;
      end
      afd_pkg::PH_CHECK: begin
        pr_error         = pr_error | err;
        res.data_byte    = b;
        res.byte_offset  = pr_length;
        res.last         = 1'b1;
        res.checksum_ok  = (pr_sum == b);
        res.frame_length = pr_length;
        // Status classes above tx failure, and a status byte never reached, are unknown.
        if (pr_status_seen &&
            (pr_status <= afd_pkg::BYTE_W'(afd_pkg::STATUS_TX_FAILURE))) begin
          res.status_code = pr_status[afd_pkg::CODE_W-1:0];
        end else begin
          res.status_code = afd_pkg::STATUS_UNKNOWN;
        end
        res.status_seen  = pr_status_seen;
        res.error_seen   = pr_error;
        deframed_q.push_back(res);
        pr_phase = afd_pkg::PH_HUNT;
      end
      default: pr_phase = afd_pkg::PH_HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Sample both channels: check deframed bytes, predict from accepted bytes, watch for a hang.
  always @(posedge clk_i) begin : monitor
    deframed_t want;
    in_fire  = rx_ch.valid && rx_ch.ready;
    out_fire = tx_ch.valid && tx_ch.ready;
    if (out_fire) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual data %0h offset %0h last %0b",
                 $time, tx_ch.data_byte, tx_ch.byte_offset, tx_ch.last);
        fail_count++;
      end else begin
        want = deframed_q.pop_front();
        check_field("data_byte", 16'(want.data_byte), 16'(tx_ch.data_byte));
        check_field("byte_offset", want.byte_offset, tx_ch.byte_offset);
        check_field("last", 16'(want.last), 16'(tx_ch.last));
        check_field("checksum_ok", 16'(want.checksum_ok), 16'(tx_ch.checksum_ok));
        check_field("frame_length", want.frame_length, tx_ch.frame_length);
        check_field("status_code", 16'(want.status_code), 16'(tx_ch.status_code));
        check_field("status_seen", 16'(want.status_seen), 16'(tx_ch.status_seen));
        check_field("error_seen", 16'(want.error_seen), 16'(tx_ch.error_seen));
      end
    end
    if (in_fire) deframe_step(rx_ch.rx_byte, rx_ch.line_error);

    // Only time with work outstanding and no progress counts toward a hang.
    if (in_fire || out_fire ||
        (pending_q.size() == 0 && !rx_ch.valid && deframed_q.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, stuck_cycles);
        $display("api_frame_deframer_core_test failed");
        $finish;
      end
    end
  end

  // Byte driver: bursts of random length separated by random gaps, none under no_idle.
  always @(negedge clk_i) begin : driver
    rx_item_t item;
    if (rx_ch.valid && !in_fire) begin
      // The offered item has not been taken yet; hold it.
    end else if (gap_left != 0) begin
      rx_ch.valid <= 1'b0;
      gap_left--;
    end else if (pending_q.size() != 0) begin
      item = pending_q.pop_front();
      rx_ch.valid      <= 1'b1;
      rx_ch.rx_byte    <= item.rx_byte;
      rx_ch.line_error <= item.line_error;
      if (burst_left != 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = no_idle ? 0 : $urandom_range(0, 12);
      end
    end else begin
      rx_ch.valid <= 1'b0;
    end
  end

  // Receiver: long hold-off on request, ready under no_idle, else a varying stall mask.
  always @(negedge clk_i) begin : receiver
    if (hold_left != 0) begin
      tx_ch.ready <= 1'b0;
      hold_left--;
    end else if (no_idle) begin
      tx_ch.ready <= 1'b1;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 16'hFFFF;
          1:       stall_mask = 16'($urandom);
          2:       stall_mask = 16'($urandom) & 16'($urandom);
          default: stall_mask = 16'($urandom) | 16'($urandom);
        endcase
        pattern_age = $urandom_range(16, 96);
      end
      pattern_age--;
      tx_ch.ready <= stall_mask[pattern_idx];
      pattern_idx <= pattern_idx + 1'b1;
    end
  end

  function automatic bit rare_error();
    return ($urandom_range(0, 19) == 0);
  endfunction

  function automatic void push_byte(input logic [afd_pkg::BYTE_W-1:0] b, input logic err);
    rx_item_t item;
    item.rx_byte    = b;
    item.line_error = err;
    pending_q.push_back(item);
    queued_items++;
  endfunction

  // One register write over the configuration port.
  task automatic reg_write(input logic [afd_pkg::APB_ADDR_W-1:0] addr,
                           input logic [afd_pkg::APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes both registers; the unused upper bits of the word carry random junk.
  task automatic configure(input logic [afd_pkg::BYTE_W-1:0]   delim,
                           input logic [afd_pkg::OFFSET_W-1:0] offset);
    logic [afd_pkg::APB_DATA_W-1:0] word;
    word = $urandom;
    word[afd_pkg::BYTE_W-1:0] = delim;
    reg_write({afd_pkg::REG_START_DELIM, 2'b00}, word);
    cfg_delim = delim;
    word = $urandom;
    word[afd_pkg::OFFSET_W-1:0] = offset;
    reg_write({afd_pkg::REG_STATUS_OFFSET, 2'b00}, word);
    cfg_status_off = offset;
  endtask

  // Waits until every byte is taken and every deframed byte has come out.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || rx_ch.valid || deframed_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // A frame with random content; a few carry a bad checksum or are cut short.
  task automatic queue_random_frame();
    rx_item_t                   frame_q[$];
    rx_item_t                   item;
    int unsigned                len;
    int unsigned                keep;
    int unsigned                sel;
    logic [afd_pkg::BYTE_W-1:0] sum;
    logic [afd_pkg::BYTE_W-1:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 70) len = $urandom_range(0, 8);
    else if (sel < 97) len = $urandom_range(9, 40);
    else len = $urandom_range(256, 300);
    sum = afd_pkg::SUM_SEED;
    item.rx_byte = cfg_delim;
    item.line_error = ($urandom_range(0, 9) == 0);
    frame_q.push_back(item);
    item.rx_byte = len[15:8];
    item.line_error = rare_error();
    frame_q.push_back(item);
    item.rx_byte = len[7:0];
    item.line_error = rare_error();
    frame_q.push_back(item);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == cfg_status_off && $urandom_range(0, 3) != 0) b = 8'($urandom_range(0, 7));
      else b = 8'($urandom);
      sum = sum - b;
      item.rx_byte = b;
      item.line_error = rare_error();
      frame_q.push_back(item);
    end
    if ($urandom_range(0, 9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    item.rx_byte = sum;
    item.line_error = rare_error();
    frame_q.push_back(item);
    keep = frame_q.size();
    if ($urandom_range(0, 9) == 0) keep = $urandom_range(1, frame_q.size() - 1);
    for (int unsigned i = 0; i < keep; i++) push_byte(frame_q[i].rx_byte, frame_q[i].line_error);
  endtask

  // A random mix of frames and line noise between them.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned                target;
    logic [afd_pkg::BYTE_W-1:0] b;
    target = queued_items + count;
    while (queued_items < target) begin
      if ($urandom_range(0, 3) == 0) begin
        b = 8'($urandom);
        if (b == cfg_delim) b = b ^ 8'h01;
        push_byte(b, $urandom_range(0, 3) == 0);
      end else begin
        queue_random_frame();
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    logic [afd_pkg::BYTE_W-1:0] sum;
    logic [afd_pkg::BYTE_W-1:0] b;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = '0;
    rx_ch.line_error = 1'b0;
    tx_ch.ready      = 1'b0;
    queued_items     = 0;
    fail_count       = 0;
    stuck_cycles     = 0;
    burst_left       = 0;
    gap_left         = 0;
    hold_left        = 0;
    pattern_age      = 0;
    stall_mask       = 16'hFFFF;
    pattern_idx      = '0;
    no_idle          = 1'b0;
    cfg_delim        = afd_pkg::START_DELIM_RST;
    cfg_status_off   = afd_pkg::STATUS_OFFSET_RST;
    pr_phase         = afd_pkg::PH_HUNT;
    pr_length        = '0;
    pr_count         = '0;
    pr_sum           = afd_pkg::SUM_SEED;
    pr_status        = '0;
    pr_status_seen   = 1'b0;
    pr_error         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset settings. A line error while hunting is ignored.
    push_byte(8'h00, 1'b1);
    // Zero length: the byte after the length is the checksum.
    push_byte(afd_pkg::START_DELIM_RST, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(afd_pkg::SUM_SEED, 1'b0);
    // Fifteen data bytes with extreme values, a line error inside, status at offset 14.
    push_byte(afd_pkg::START_DELIM_RST, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0F, 1'b0);
    sum = afd_pkg::SUM_SEED;
    for (int i = 0; i < 15; i++) begin
      if (i == 0) b = 8'hFF;
      else if (i == 1) b = 8'h00;
      else if (i == 14) b = 8'h03;
      else b = 8'($urandom);
      sum = sum - b;
      push_byte(b, i == 5);
    end
    push_byte(sum, 1'b0);
    wait_drained();

    // Random phases with the register extremes among the settings.
    for (int phase_idx = 0; phase_idx < 8; phase_idx++) begin
      case (phase_idx)
        0:       configure(8'h00, 16'h0000);
        1:       configure(8'hFF, 16'hFFFF);
        2:       configure(afd_pkg::START_DELIM_RST, 16'd3);
        3:       configure(8'($urandom), 16'($urandom_range(0, 12)));
        default: configure(8'($urandom), 16'($urandom_range(0, 40)));
      endcase
      no_idle = (phase_idx == 2);
      // The receiver holds off while the sender keeps offering, so the block fills up.
      if (phase_idx == 3) hold_left = HOLD_CYCLES;
      queue_random_traffic(220);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("api_frame_deframer_core_test passed");
    end else begin
      $display("api_frame_deframer_core_test failed");
    end
    $finish;
  end

endmodule
